>>> sv/itun_pkg.sv
// Shared types, codes and constants of the indexed triangle unit normal block.
// Used by the controller, the datapath and the top level; depends on nothing.
package itun_pkg;

    localparam int VERTEX_COUNT_DEF     = 256;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int COORD_W              = 32;
    localparam int INDEX_W              = 8;
    localparam int NORMAL_W             = 16;
    localparam int SAT_MAX              = 32767;

    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_RD_A      = 5'd1;
    localparam logic [4:0] OP_RD_B      = 5'd2;
    localparam logic [4:0] OP_EDGE1     = 5'd3;
    localparam logic [4:0] OP_EDGE2     = 5'd4;
    localparam logic [4:0] OP_MUL       = 5'd5;
    localparam logic [4:0] OP_ABS       = 5'd6;
    localparam logic [4:0] OP_SHIFT     = 5'd7;
    localparam logic [4:0] OP_SQ        = 5'd8;
    localparam logic [4:0] OP_SQRT_INIT = 5'd9;
    localparam logic [4:0] OP_SQRT      = 5'd10;
    localparam logic [4:0] OP_DIV_INIT  = 5'd11;
    localparam logic [4:0] OP_DIV       = 5'd12;
    localparam logic [4:0] OP_DIV_END   = 5'd13;
    localparam logic [4:0] OP_DEGEN     = 5'd14;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] step;
        logic       acc_write;
        logic       acc_tri;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic c_zero;
        logic upper_nz;
        logic out_free;
    } stat_t;

    function automatic int norm_limit(input int frac_bits);
        int lim;
        lim = 1 << frac_bits;
        if (lim > SAT_MAX)
        begin
            lim = SAT_MAX;
        end
        return lim;
    endfunction

endpackage

>>> sv/indexed_triangle_unit_normal_unit.sv
// Top level of the indexed triangle unit normal block.
// Joins itun_ctrl and itun_dp; depends on itun_pkg.
//
// Write beats (func 0) store a Q16.16 vertex in the table and give no result.
// A triangle beat (func 1) reads its three vertices through the single read port of the
// vertex memory, forms the exact cross product with one shared 33x33 multiplier, shifts
// the components right one bit a cycle until they fit in 31 bits (0 to 34 shifts),
// squares them, runs a bit-serial square root, and divides each component with a
// restoring divider that forms NORMAL_FRAC_BITS+1 quotient bits.
// One triangle is in work at a time; the finished result sits in an output register
// so the next beat is taken while it waits.
module indexed_triangle_unit_normal_unit #(
    parameter int VERTEX_COUNT     = itun_pkg::VERTEX_COUNT_DEF,
    parameter int NORMAL_FRAC_BITS = itun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic [itun_pkg::INDEX_W-1:0]         vert_index_a,
    input  logic [itun_pkg::INDEX_W-1:0]         vert_index_b,
    input  logic [itun_pkg::INDEX_W-1:0]         vert_index_c,
    input  logic signed [itun_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [itun_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [itun_pkg::COORD_W-1:0]  coord_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [itun_pkg::NORMAL_W-1:0] normal_x,
    output logic signed [itun_pkg::NORMAL_W-1:0] normal_y,
    output logic signed [itun_pkg::NORMAL_W-1:0] normal_z,
    output logic                                 degenerate
);

    localparam logic signed [itun_pkg::NORMAL_W-1:0] LIM_S =
        itun_pkg::NORMAL_W'(itun_pkg::norm_limit(NORMAL_FRAC_BITS));

    itun_pkg::cmd_t  cmd;
    itun_pkg::stat_t stat;

    itun_ctrl #(
        .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    itun_dp #(
        .VERTEX_COUNT     (VERTEX_COUNT),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .vert_index_a (vert_index_a),
        .vert_index_b (vert_index_b),
        .vert_index_c (vert_index_c),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .degenerate   (degenerate)
    );

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("Degenerate beat carries a nonzero normal.");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x <= LIM_S && normal_x >= -LIM_S
            && normal_y <= LIM_S && normal_y >= -LIM_S
            && normal_z <= LIM_S && normal_z >= -LIM_S)
        else $error("Normal component exceeds the unit range.");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !func |=> !$rose(out_valid))
        else $error("A vertex write produced a result beat.");
`endif

endmodule

>>> sv/itun_ctrl.sv
// Sequencing state machine of the triangle unit normal block.
// Depends on itun_pkg for the command and status structs and the operation codes.
module itun_ctrl #(
    parameter int NORMAL_FRAC_BITS = itun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            func,
    output logic            in_stall,
    input  itun_pkg::stat_t stat,
    output itun_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RDA       = 4'd1;
    localparam logic [3:0] S_RDB       = 4'd2;
    localparam logic [3:0] S_EDGE1     = 4'd3;
    localparam logic [3:0] S_EDGE2     = 4'd4;
    localparam logic [3:0] S_MUL       = 4'd5;
    localparam logic [3:0] S_ABS       = 4'd6;
    localparam logic [3:0] S_SHIFT     = 4'd7;
    localparam logic [3:0] S_SQ        = 4'd8;
    localparam logic [3:0] S_SQRT_INIT = 4'd9;
    localparam logic [3:0] S_SQRT      = 4'd10;
    localparam logic [3:0] S_DIV_INIT  = 4'd11;
    localparam logic [3:0] S_DIV       = 4'd12;
    localparam logic [3:0] S_DIV_END   = 4'd13;
    localparam logic [3:0] S_DEGEN     = 4'd14;
    localparam logic [3:0] S_OUT       = 4'd15;

    localparam logic [5:0] MUL_LAST  = 6'd6;
    localparam logic [5:0] SQ_LAST   = 6'd3;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'(NORMAL_FRAC_BITS);
    localparam logic [1:0] K_LAST    = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.op     = itun_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (func)
                    begin
                        cmd.acc_tri = 1'b1;
                        state_next  = S_RDA;
                    end
                    else
                    begin
                        cmd.acc_write = 1'b1;
                    end
                end
            end
            S_RDA:
            begin
                cmd.op     = itun_pkg::OP_RD_A;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.op     = itun_pkg::OP_RD_B;
                state_next = S_EDGE1;
            end
            S_EDGE1:
            begin
                cmd.op     = itun_pkg::OP_EDGE1;
                state_next = S_EDGE2;
            end
            S_EDGE2:
            begin
                cmd.op     = itun_pkg::OP_EDGE2;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op   = itun_pkg::OP_MUL;
                cmd.step = cnt_reg[2:0];
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_ABS;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_ABS:
            begin
                cmd.op     = itun_pkg::OP_ABS;
                state_next = stat.c_zero ? S_DEGEN : S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.op = itun_pkg::OP_SHIFT;
                if (!stat.upper_nz)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.op   = itun_pkg::OP_SQ;
                cmd.step = cnt_reg[2:0];
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = itun_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = itun_pkg::OP_SQRT;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = '0;
                    k_next     = '0;
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = itun_pkg::OP_DIV_INIT;
                cmd.step   = {1'b0, k_reg};
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = itun_pkg::OP_DIV;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_DIV_END:
            begin
                cmd.op   = itun_pkg::OP_DIV_END;
                cmd.step = {1'b0, k_reg};
                if (k_reg == K_LAST)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end
            S_DEGEN:
            begin
                cmd.op     = itun_pkg::OP_DEGEN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/itun_dp.sv
// Datapath of the triangle unit normal block: vertex memory, shared multiplier,
// shift normalizer, bit-serial square root and restoring divider, output register.
// Depends on itun_pkg for the command and status structs and the operation codes.
module itun_dp #(
    parameter int VERTEX_COUNT     = itun_pkg::VERTEX_COUNT_DEF,
    parameter int NORMAL_FRAC_BITS = itun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  itun_pkg::cmd_t                       cmd,
    output itun_pkg::stat_t                      stat,
    input  logic [itun_pkg::INDEX_W-1:0]         vert_index_a,
    input  logic [itun_pkg::INDEX_W-1:0]         vert_index_b,
    input  logic [itun_pkg::INDEX_W-1:0]         vert_index_c,
    input  logic signed [itun_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [itun_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [itun_pkg::COORD_W-1:0]  coord_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [itun_pkg::NORMAL_W-1:0] normal_x,
    output logic signed [itun_pkg::NORMAL_W-1:0] normal_y,
    output logic signed [itun_pkg::NORMAL_W-1:0] normal_z,
    output logic                                 degenerate
);

    localparam int IW    = $clog2(VERTEX_COUNT);
    localparam int CW    = itun_pkg::COORD_W;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int MW    = PW - 1;
    localparam int QW    = NORMAL_FRAC_BITS + 1;
    localparam int NW    = itun_pkg::NORMAL_W;
    localparam int LIM   = itun_pkg::norm_limit(NORMAL_FRAC_BITS);
    localparam int NIDX  = 1 << itun_pkg::INDEX_W;

    logic [IW-1:0] mod_tab [NIDX];
    for (genvar g = 0; g < NIDX; g++)
    begin : g_mod
        assign mod_tab[g] = IW'(g % VERTEX_COUNT);
    end

    logic [3*CW-1:0] mem [VERTEX_COUNT];
    logic [3*CW-1:0] rd_q_reg;
    logic [IW-1:0]   rd_addr;

    logic [IW-1:0] ia_reg, ib_reg, ic_reg;
    logic signed [CW-1:0] p1x_reg, p1y_reg, p1z_reg;
    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [EW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_next, prod_reg, acc_reg;
    logic signed [PW-1:0] c_reg [3];
    logic [MW-1:0]        mag_reg [3];
    logic [2:0]           neg_reg;
    logic [63:0]          sum_reg;
    logic [63:0]          v_reg, r_reg, bit_reg, sq_t;
    logic [31:0]          len;
    logic [63:0]          rem_reg, d_reg;
    logic [QW-1:0]        q_reg;
    logic [QW-1:0]        q_sat;
    logic [NW-1:0]        q_mag;
    logic [NW-1:0]        res_reg [3];
    logic                 deg_reg;
    logic                 out_valid_reg;
    logic [2:0]           pstep;
    logic [1:0]           ck;
    logic signed [CW-1:0] rx, ry, rz;

    assign rx = rd_q_reg[3*CW-1:2*CW];
    assign ry = rd_q_reg[2*CW-1:CW];
    assign rz = rd_q_reg[CW-1:0];

    always_comb
    begin
        rd_addr = ia_reg;
        if (cmd.op == itun_pkg::OP_RD_B)
        begin
            rd_addr = ib_reg;
        end
        else if (cmd.op == itun_pkg::OP_EDGE1)
        begin
            rd_addr = ic_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_write)
        begin
            mem[mod_tab[vert_index_a]] <= {coord_x, coord_y, coord_z};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q_reg <= mem[rd_addr];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == itun_pkg::OP_MUL)
        begin
            unique case (cmd.step)
                3'd0: begin mul_a = e1y_reg; mul_b = e2z_reg; end
                3'd1: begin mul_a = e2y_reg; mul_b = e1z_reg; end
                3'd2: begin mul_a = e1z_reg; mul_b = e2x_reg; end
                3'd3: begin mul_a = e1x_reg; mul_b = e2z_reg; end
                3'd4: begin mul_a = e1x_reg; mul_b = e2y_reg; end
                3'd5: begin mul_a = e1y_reg; mul_b = e2x_reg; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (cmd.op == itun_pkg::OP_SQ && cmd.step < 3'd3)
        begin
            mul_a = $signed({2'b00, mag_reg[cmd.step[1:0]][30:0]});
            mul_b = mul_a;
        end
    end

    assign prod_next = mul_a * mul_b;
    assign pstep     = cmd.step - 3'd1;
    assign ck        = cmd.step[1:0];
    assign sq_t      = r_reg + bit_reg;
    assign len       = (r_reg[31:0] == 32'd0) ? 32'd1 : r_reg[31:0];
    assign q_sat     = (q_reg > QW'(LIM)) ? QW'(LIM) : q_reg;
    assign q_mag     = NW'(q_sat);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        unique case (cmd.op)
            itun_pkg::OP_RD_B:
            begin
                p1x_reg <= rx;
                p1y_reg <= ry;
                p1z_reg <= rz;
            end
            itun_pkg::OP_EDGE1:
            begin
                e1x_reg <= EW'(p1x_reg) - EW'(rx);
                e1y_reg <= EW'(p1y_reg) - EW'(ry);
                e1z_reg <= EW'(p1z_reg) - EW'(rz);
            end
            itun_pkg::OP_EDGE2:
            begin
                e2x_reg <= EW'(p1x_reg) - EW'(rx);
                e2y_reg <= EW'(p1y_reg) - EW'(ry);
                e2z_reg <= EW'(p1z_reg) - EW'(rz);
            end
            itun_pkg::OP_MUL:
            begin
                if (cmd.step != 3'd0)
                begin
                    if (!pstep[0])
                    begin
                        acc_reg <= prod_reg;
                    end
                    else
                    begin
                        c_reg[pstep[2:1]] <= acc_reg - prod_reg;
                    end
                end
            end
            itun_pkg::OP_ABS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k] <= c_reg[k][PW-1];
                    mag_reg[k] <= c_reg[k][PW-1] ? MW'(-c_reg[k]) : MW'(c_reg[k]);
                end
            end
            itun_pkg::OP_SHIFT:
            begin
                if (stat.upper_nz)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end
            end
            itun_pkg::OP_SQ:
            begin
                if (cmd.step == 3'd1)
                begin
                    sum_reg <= prod_reg[63:0];
                end
                else if (cmd.step != 3'd0)
                begin
                    sum_reg <= sum_reg + prod_reg[63:0];
                end
            end
            itun_pkg::OP_SQRT_INIT:
            begin
                v_reg   <= sum_reg;
                r_reg   <= '0;
                bit_reg <= 64'd1 << 62;
            end
            itun_pkg::OP_SQRT:
            begin
                if (v_reg >= sq_t)
                begin
                    v_reg <= v_reg - sq_t;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            itun_pkg::OP_DIV_INIT:
            begin
                rem_reg <= (64'(mag_reg[ck][30:0]) << NORMAL_FRAC_BITS) + 64'(len >> 1);
                d_reg   <= 64'(len) << NORMAL_FRAC_BITS;
                q_reg   <= '0;
            end
            itun_pkg::OP_DIV:
            begin
                if (rem_reg >= d_reg)
                begin
                    rem_reg <= rem_reg - d_reg;
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[QW-2:0], 1'b0};
                end
                d_reg <= d_reg >> 1;
            end
            itun_pkg::OP_DIV_END:
            begin
                res_reg[ck] <= neg_reg[ck] ? (NW'(0) - q_mag) : q_mag;
                deg_reg     <= 1'b0;
            end
            itun_pkg::OP_DEGEN:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    res_reg[k] <= '0;
                end
                deg_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_tri)
        begin
            ia_reg <= mod_tab[vert_index_a];
            ib_reg <= mod_tab[vert_index_b];
            ic_reg <= mod_tab[vert_index_c];
        end
        if (cmd.load_out)
        begin
            normal_x   <= res_reg[0];
            normal_y   <= res_reg[1];
            normal_z   <= res_reg[2];
            degenerate <= deg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.c_zero   = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
    assign stat.upper_nz = |((mag_reg[0] | mag_reg[1] | mag_reg[2]) >> 31);

endmodule

>>> tb/tb.sv
// Self-checking testbench for indexed_triangle_unit_normal_unit: fills the vertex table, sends
// triangle beats and checks every unit normal against a predictor held in this file.
// Depends on itun_pkg and the RTL of the block only.
module tb;

    typedef struct {
        logic signed [itun_pkg::NORMAL_W-1:0] nx;
        logic signed [itun_pkg::NORMAL_W-1:0] ny;
        logic signed [itun_pkg::NORMAL_W-1:0] nz;
        logic                                 degen;
    } normal_t;

    localparam int FRAC     = itun_pkg::NORMAL_FRAC_BITS_DEF;
    localparam int VCNT     = itun_pkg::VERTEX_COUNT_DEF;
    localparam int LIMIT    = 3000000;
    localparam bit FN_WRITE = 1'b0;
    localparam bit FN_TRI   = 1'b1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [itun_pkg::INDEX_W-1:0] vert_index_a;
    logic [itun_pkg::INDEX_W-1:0] vert_index_b;
    logic [itun_pkg::INDEX_W-1:0] vert_index_c;
    logic signed [itun_pkg::COORD_W-1:0] coord_x;
    logic signed [itun_pkg::COORD_W-1:0] coord_y;
    logic signed [itun_pkg::COORD_W-1:0] coord_z;
    logic out_valid;
    logic out_stall;
    logic signed [itun_pkg::NORMAL_W-1:0] normal_x;
    logic signed [itun_pkg::NORMAL_W-1:0] normal_y;
    logic signed [itun_pkg::NORMAL_W-1:0] normal_z;
    logic degenerate;

    logic signed [itun_pkg::COORD_W-1:0] vtx_x [VCNT];
    logic signed [itun_pkg::COORD_W-1:0] vtx_y [VCNT];
    logic signed [itun_pkg::COORD_W-1:0] vtx_z [VCNT];
    bit vtx_written [VCNT];

    normal_t pending_normals[$];
    int mismatches;
    int cycles;
    bit idling_on;
    int out_hold;

    indexed_triangle_unit_normal_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .vert_index_a(vert_index_a), .vert_index_b(vert_index_b),
        .vert_index_c(vert_index_c), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic normal_t face_normal(input int ia, input int ib, input int ic);
        logic signed [32:0] e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [127:0] cr [3];
        logic [127:0] mag [3];
        logic [63:0] m [3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] t;
        logic [63:0] q;
        int maxb;
        int sh;
        normal_t r;
        e1x = vtx_x[ia] - vtx_x[ib];
        e1y = vtx_y[ia] - vtx_y[ib];
        e1z = vtx_z[ia] - vtx_z[ib];
        e2x = vtx_x[ia] - vtx_x[ic];
        e2y = vtx_y[ia] - vtx_y[ic];
        e2z = vtx_z[ia] - vtx_z[ic];
        cr[0] = e1y * e2z - e2y * e1z;
        cr[1] = e1z * e2x - e1x * e2z;
        cr[2] = e1x * e2y - e1y * e2x;
        maxb = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
            for (int b = 0; b < 128; b++)
            begin
                if (mag[k][b] && b + 1 > maxb)
                begin
                    maxb = b + 1;
                end
            end
        end
        r.nx = '0;
        r.ny = '0;
        r.nz = '0;
        r.degen = 1'b0;
        if (maxb == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        sh = maxb > 31 ? maxb - 31 : 0;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            m[k] = 64'(mag[k] >> sh);
            sum += m[k] * m[k];
        end
        len = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = len | (64'd1 << i);
            if (t * t <= sum)
            begin
                len = t;
            end
        end
        if (len == 0)
        begin
            len = 1;
        end
        for (int k = 0; k < 3; k++)
        begin
            q = ((m[k] << FRAC) + len / 2) / len;
            if (q > 64'(itun_pkg::norm_limit(FRAC)))
            begin
                q = 64'(itun_pkg::norm_limit(FRAC));
            end
            if (cr[k] < 0)
            begin
                q = -q;
            end
            case (k)
                0: r.nx = q[itun_pkg::NORMAL_W-1:0];
                1: r.ny = q[itun_pkg::NORMAL_W-1:0];
                default: r.nz = q[itun_pkg::NORMAL_W-1:0];
            endcase
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input bit fn, input int a, input int b, input int c,
                             input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        vert_index_a <= a[7:0];
        vert_index_b <= b[7:0];
        vert_index_c <= c[7:0];
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (fn == FN_WRITE)
        begin
            vtx_x[a] = x;
            vtx_y[a] = y;
            vtx_z[a] = z;
            vtx_written[a] = 1'b1;
        end
        else
        begin
            pending_normals.push_back(face_normal(a, b, c));
        end
    endtask

    task automatic write_vertex(input int a, input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
        send_beat(FN_WRITE, a, $urandom_range(0, 255), $urandom_range(0, 255), x, y, z);
    endtask

    task automatic send_triangle(input int a, input int b, input int c);
        send_beat(FN_TRI, a, b, c, $urandom, $urandom, $urandom);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 400000)) - 200000) << 8;
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    task automatic test_directed();
        write_vertex(0, 32'h80000000, 32'h80000000, 32'h80000000);
        write_vertex(255, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        write_vertex(1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        write_vertex(2, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        write_vertex(3, 32'h00010000, 32'h0, 32'h0);
        write_vertex(4, 32'h0, 32'h00010000, 32'h0);
        write_vertex(5, 32'h0, 32'h0, 32'h0);
        write_vertex(6, 32'h00020000, 32'h0, 32'h0);
        write_vertex(7, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        write_vertex(8, 32'h0, 32'h0, 32'h1);
        write_vertex(9, 32'h1, 32'h1, 32'h0);
        send_triangle(5, 5, 5);
        send_triangle(5, 3, 6);
        send_triangle(5, 3, 4);
        send_triangle(5, 4, 3);
        send_triangle(0, 255, 1);
        send_triangle(0, 1, 2);
        send_triangle(255, 7, 2);
        send_triangle(0, 7, 255);
        send_triangle(5, 8, 9);
        send_triangle(1, 2, 7);
        send_triangle(9, 5, 8);
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < VCNT; i++)
        begin
            write_vertex(i, rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic test_random_mesh(input int beats);
        int a;
        int b;
        int c;
        for (int n = 0; n < beats; n++)
        begin
            a = $urandom_range(0, 255);
            if ($urandom_range(0, 4) == 0)
            begin
                write_vertex(a, rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                b = $urandom_range(0, 255);
                c = $urandom_range(0, 255);
                if ($urandom_range(0, 15) == 0)
                begin
                    b = a;
                end
                if (vtx_written[a] && vtx_written[b] && vtx_written[c])
                begin
                    send_triangle(a, b, c);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        normal_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat: %0d %0d %0d degenerate %0b",
                             normal_x, normal_y, normal_z, degenerate);
                end
            end
            else
            begin
                want = pending_normals.pop_front();
                if (normal_x !== want.nx || normal_y !== want.ny || normal_z !== want.nz
                    || degenerate !== want.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                                 want.nx, want.ny, want.nz, want.degen,
                                 normal_x, normal_y, normal_z, degenerate);
                    end
                end
            end
        end
        if (out_hold > 0)
        begin
            out_hold <= out_hold - 1;
            out_stall <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            out_hold <= $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        int wait_cycles;
        mismatches = 0;
        cycles = 0;
        out_hold = 0;
        idling_on = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = FN_WRITE;
        vert_index_a = '0;
        vert_index_b = '0;
        vert_index_c = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_table();
        test_random_mesh(1100);
        idling_on = 1'b0;
        test_random_mesh(250);
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_normals.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_normals.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
